[hw/rtl/armt_pkg.sv]
// armt_pkg: types and codes shared by the address region map table
// no dependencies; compiled first

package armt_pkg;

  localparam int unsigned AW = 64;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_ERASE  = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCONS     = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd3;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] length;
    logic [AW-1:0] offset;
    logic          anon;
  } ent_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [AW-1:0] start;
    logic [AW-1:0] length;
    logic [AW-1:0] offset;
    logic          anon;
    logic [AW-1:0] trans;
  } res_t;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic          sub;
  } alu_req_t;

  typedef struct packed {
    logic [AW-1:0] res;
    logic          carry;
    logic          lt;
    logic          eq;
  } alu_rsp_t;

endpackage

[hw/rtl/armt_in_if.sv]
// armt_in_if: request channel of the region map table
// no dependencies

interface armt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] address;
  logic [63:0] length;
  logic [63:0] file_offset;
  logic        anonymous;

  modport source (output valid, action, address, length, file_offset, anonymous, input ready);
  modport sink   (input valid, action, address, length, file_offset, anonymous, output ready);
endinterface

[hw/rtl/armt_out_if.sv]
// armt_out_if: result channel of the region map table
// no dependencies

interface armt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] region_start;
  logic [63:0] region_length;
  logic [63:0] region_offset;
  logic        region_is_anonymous;
  logic [63:0] translated_offset;

  modport source (output valid, status, region_start, region_length, region_offset,
                  region_is_anonymous, translated_offset, input ready);
  modport sink   (input valid, status, region_start, region_length, region_offset,
                  region_is_anonymous, translated_offset, output ready);
endinterface

[hw/rtl/address_region_map_table_top.sv]
// Address region map table: keeps up to TABLE_ENTRIES disjoint address regions
// and serves insert (with merging of agreeing neighbors), erase and lookup words.
// One word is taken at a time; in_ch.ready is high only while the block is idle.
// Each word walks the table through one shared 64-bit add/compare unit: a free
// or empty slot needs no add/compare step, a stored region is checked in a series
// of add/compare steps. Insert restarts the walk after every merge, and erase adds
// one walk per kept remainder before the table is updated and the result is
// presented.
// depends on armt_pkg, armt_in_if, armt_out_if, armt_alu, armt_ctrl

module address_region_map_table_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  armt_in_if.sink     in_ch,
  armt_out_if.source  out_ch
);
  import armt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;
  logic          wr_en;
  ent_t          wr_ent;
  ent_t          rd_ent_r;
  ent_t          mem_r [TABLE_ENTRIES];

  // region store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_ent;
    end
    rd_ent_r <= mem_r[rd_idx];
  end

  armt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  armt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp),
    .rd_idx  (rd_idx),
    .rd_ent  (rd_ent_r),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_ent  (wr_ent)
  );
endmodule

[hw/rtl/armt_alu.sv]
// armt_alu: shared 64-bit add / subtract-compare unit
// depends on armt_pkg

module armt_alu (
  input  armt_pkg::alu_req_t req,
  output armt_pkg::alu_rsp_t rsp
);
  import armt_pkg::*;

  logic [AW:0] sum;

  always_comb begin
    sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{AW{1'b0}}, req.sub};
    rsp.res   = sum[AW-1:0];
    rsp.carry = sum[AW];
    rsp.lt    = req.sub & ~sum[AW];
    rsp.eq    = (sum[AW-1:0] == '0);
  end
endmodule

[hw/rtl/armt_ctrl.sv]
// armt_ctrl: sequencer for insert, erase and lookup over the region table
// depends on armt_pkg, armt_in_if, armt_out_if; drives armt_alu and the table memory

module armt_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  armt_in_if.sink                            in_ch,
  armt_out_if.source                         out_ch,
  output armt_pkg::alu_req_t                 alu_req,
  input  armt_pkg::alu_rsp_t                 alu_rsp,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   rd_idx,
  input  armt_pkg::ent_t                     rd_ent,
  output logic                               wr_en,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   wr_idx,
  output armt_pkg::ent_t                     wr_ent
);
  import armt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN, S_EVAL, S_END, S_LEN, S_WR2, S_OUT
  } state_t;

  typedef enum logic [1:0] {M_LOOK, M_PUT, M_CUT} mode_t;

  // remainders keep their end address in the length field
  typedef struct packed {
    logic [1:0]               act;
    mode_t                    mode;
    logic                     erase;
    logic [AW-1:0]            s;
    logic [AW-1:0]            e;
    logic [AW-1:0]            o;
    logic                     an;
    logic [AW-1:0]            len;
    logic [AW-1:0]            oe;
    logic [AW-1:0]            tmp;
    logic [AW-1:0]            d2;
    logic                     oes_eq;
    logic                     ose_eq;
    logic                     slt;
    logic                     seq;
    logic                     elt;
    logic                     eeq;
    logic                     hl;
    logic                     hr;
    logic [IW-1:0]            idx;
    logic [2:0]               step;
    logic                     free_v;
    logic [IW-1:0]            free_idx;
    logic                     pend_v;
    logic [IW-1:0]            pend_idx;
    ent_t                     pend_ent;
    ent_t [1:0]               rem;
    logic [1:0]               rem_n;
    logic                     rem_i;
    logic [TABLE_ENTRIES-1:0] kill;
    res_t                     res;
  } ctx_t;

  state_t                   state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  res_t                     out_r, out_nxt;
  ctx_t                     ctx_r, ctx_nxt;

  logic       adv;
  logic       restart;
  logic       ok;
  logic       c_in;
  logic       c_cov;
  logic [1:0] n;

  assign rd_idx      = ctx_r.idx;
  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = out_r.status;
  assign out_ch.region_start        = out_r.start;
  assign out_ch.region_length       = out_r.length;
  assign out_ch.region_offset       = out_r.offset;
  assign out_ch.region_is_anonymous = out_r.anon;
  assign out_ch.translated_offset   = out_r.trans;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ctx_nxt       = ctx_r;
    alu_req       = '0;
    wr_en         = 1'b0;
    wr_idx        = ctx_r.free_idx;
    wr_ent        = '0;
    adv           = 1'b0;
    restart       = 1'b0;
    n             = ctx_r.rem_n;
    ok            = (ctx_r.an & rd_ent.anon) | (~ctx_r.an & ~rd_ent.anon & alu_rsp.eq);
    c_in          = ~ctx_r.slt & (ctx_r.elt | ctx_r.eeq);
    c_cov         = (ctx_r.slt | ctx_r.seq) & ~ctx_r.elt;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          ctx_nxt.act = in_ch.action;
          ctx_nxt.s   = in_ch.address;
          ctx_nxt.len = in_ch.length;
          ctx_nxt.o   = in_ch.file_offset;
          ctx_nxt.an  = in_ch.anonymous;
          state_nxt   = S_START;
        end
      end

      S_START: begin
        alu_req          = '{a: ctx_r.s, b: ctx_r.len, sub: 1'b0};
        ctx_nxt.kill     = '0;
        ctx_nxt.free_v   = 1'b0;
        ctx_nxt.pend_v   = 1'b0;
        ctx_nxt.rem_n    = 2'd0;
        ctx_nxt.rem_i    = 1'b0;
        ctx_nxt.idx      = '0;
        ctx_nxt.step     = 3'd0;
        ctx_nxt.res      = '0;
        ctx_nxt.e        = alu_rsp.carry ? {AW{1'b1}} : alu_rsp.res;
        ctx_nxt.erase    = (ctx_r.act == ACT_ERASE);
        case (ctx_r.act)
          ACT_INSERT, ACT_ERASE: begin
            ctx_nxt.mode = (ctx_r.act == ACT_INSERT) ? M_PUT : M_CUT;
            if ((ctx_r.len == '0) || (&ctx_r.s)) begin
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          ACT_LOOKUP: begin
            ctx_nxt.mode = M_LOOK;
            state_nxt    = S_SCAN;
          end
          default: state_nxt = S_OUT;
        endcase
      end

      S_SCAN: begin
        if (valid_r[ctx_r.idx] && !ctx_r.kill[ctx_r.idx]) begin
          ctx_nxt.step = 3'd0;
          state_nxt    = S_EVAL;
        end else begin
          if (ctx_r.mode == M_PUT && !ctx_r.free_v &&
              !(ctx_r.pend_v && ctx_r.pend_idx == ctx_r.idx)) begin
            ctx_nxt.free_v   = 1'b1;
            ctx_nxt.free_idx = ctx_r.idx;
          end
          adv = 1'b1;
        end
      end

      S_EVAL: begin
        ctx_nxt.step = ctx_r.step + 3'd1;
        case (ctx_r.mode)
          M_LOOK: begin
            case (ctx_r.step)
              3'd0: begin
                alu_req     = '{a: ctx_r.s, b: rd_ent.start, sub: 1'b1};
                ctx_nxt.tmp = alu_rsp.res;
                adv         = alu_rsp.lt;
              end
              3'd1: begin
                alu_req = '{a: ctx_r.tmp, b: rd_ent.length, sub: 1'b1};
                adv     = ~alu_rsp.lt;
              end
              default: begin
                alu_req            = '{a: rd_ent.offset, b: ctx_r.tmp, sub: 1'b0};
                ctx_nxt.res.status = ST_OK;
                ctx_nxt.res.start  = rd_ent.start;
                ctx_nxt.res.length = rd_ent.length;
                ctx_nxt.res.offset = rd_ent.offset;
                ctx_nxt.res.anon   = rd_ent.anon;
                ctx_nxt.res.trans  = alu_rsp.res;
                state_nxt          = S_OUT;
              end
            endcase
          end

          M_PUT: begin
            case (ctx_r.step)
              3'd0: begin
                alu_req    = '{a: rd_ent.start, b: rd_ent.length, sub: 1'b0};
                ctx_nxt.oe = alu_rsp.res;
              end
              3'd1: begin
                alu_req        = '{a: ctx_r.oe, b: ctx_r.s, sub: 1'b1};
                ctx_nxt.oes_eq = alu_rsp.eq;
                adv            = alu_rsp.lt;
              end
              3'd2: begin
                alu_req        = '{a: rd_ent.start, b: ctx_r.e, sub: 1'b1};
                ctx_nxt.ose_eq = alu_rsp.eq;
                adv            = ~alu_rsp.lt & ~alu_rsp.eq;
              end
              3'd3: begin
                alu_req     = '{a: ctx_r.s, b: rd_ent.start, sub: 1'b1};
                ctx_nxt.slt = alu_rsp.lt;
                ctx_nxt.seq = alu_rsp.eq;
                ctx_nxt.tmp = alu_rsp.res;
              end
              3'd4: begin
                alu_req     = '{a: ctx_r.e, b: ctx_r.oe, sub: 1'b1};
                ctx_nxt.elt = alu_rsp.lt;
                ctx_nxt.eeq = alu_rsp.eq;
              end
              3'd5: begin
                alu_req    = '{a: ctx_r.o, b: rd_ent.offset, sub: 1'b1};
                ctx_nxt.d2 = alu_rsp.res;
              end
              default: begin
                // mapping agreement and merge decision
                alu_req = '{a: ctx_r.tmp, b: ctx_r.d2, sub: 1'b1};
                if (c_in || c_cov || (!ctx_r.ose_eq && !ctx_r.oes_eq)) begin
                  if (!ok) begin
                    ctx_nxt.res.status = ST_INCONS;
                    state_nxt          = S_OUT;
                  end else begin
                    restart = 1'b1;
                    if (c_in || (!c_cov && !ctx_r.slt)) begin
                      ctx_nxt.s  = rd_ent.start;
                      ctx_nxt.o  = rd_ent.offset;
                      ctx_nxt.an = rd_ent.anon;
                    end
                    if (c_in || (!c_cov && ctx_r.slt)) begin
                      ctx_nxt.e = ctx_r.oe;
                    end
                  end
                end else if (!ok) begin
                  adv = 1'b1;
                end else begin
                  restart = 1'b1;
                  if (ctx_r.ose_eq) begin
                    ctx_nxt.e = ctx_r.oe;
                  end else begin
                    ctx_nxt.s  = rd_ent.start;
                    ctx_nxt.o  = rd_ent.offset;
                    ctx_nxt.an = rd_ent.anon;
                  end
                end
                if (restart) begin
                  ctx_nxt.kill[ctx_r.idx] = 1'b1;
                end
              end
            endcase
          end

          M_CUT: begin
            case (ctx_r.step)
              3'd0: begin
                alu_req    = '{a: rd_ent.start, b: rd_ent.length, sub: 1'b0};
                ctx_nxt.oe = alu_rsp.res;
              end
              3'd1: begin
                alu_req = '{a: ctx_r.e, b: rd_ent.start, sub: 1'b1};
                adv     = alu_rsp.lt | alu_rsp.eq;
              end
              3'd2: begin
                alu_req = '{a: ctx_r.oe, b: ctx_r.s, sub: 1'b1};
                adv     = alu_rsp.lt | alu_rsp.eq;
              end
              3'd3: begin
                alu_req    = '{a: ctx_r.s, b: rd_ent.start, sub: 1'b1};
                ctx_nxt.hl = ~alu_rsp.lt & ~alu_rsp.eq;
              end
              3'd4: begin
                alu_req    = '{a: ctx_r.e, b: ctx_r.oe, sub: 1'b1};
                ctx_nxt.hr = alu_rsp.lt;
              end
              3'd5: begin
                alu_req     = '{a: ctx_r.e, b: rd_ent.start, sub: 1'b1};
                ctx_nxt.tmp = alu_rsp.res;
              end
              default: begin
                alu_req = '{a: rd_ent.offset, b: ctx_r.tmp, sub: 1'b0};
                if (ctx_r.hl && n != 2'd2) begin
                  ctx_nxt.rem[n[0]] = '{start: rd_ent.start, length: ctx_r.s,
                                        offset: rd_ent.offset, anon: rd_ent.anon};
                  n = n + 2'd1;
                end
                if (ctx_r.hr && n != 2'd2) begin
                  ctx_nxt.rem[n[0]] = '{start: ctx_r.e, length: ctx_r.oe,
                                        offset: rd_ent.anon ? rd_ent.offset : alu_rsp.res,
                                        anon: rd_ent.anon};
                  n = n + 2'd1;
                end
                ctx_nxt.rem_n           = n;
                ctx_nxt.kill[ctx_r.idx] = 1'b1;
                adv                     = 1'b1;
              end
            endcase
          end

          default: state_nxt = S_IDLE;
        endcase
      end

      S_END: begin
        case (ctx_r.mode)
          M_LOOK: begin
            ctx_nxt.res.status = ST_NOT_MAPPED;
            state_nxt          = S_OUT;
          end
          M_CUT: begin
            if (ctx_r.rem_n == 2'd0) begin
              valid_nxt = valid_r & ~ctx_r.kill;
              state_nxt = S_OUT;
            end else begin
              ctx_nxt.s    = ctx_r.rem[0].start;
              ctx_nxt.e    = ctx_r.rem[0].length;
              ctx_nxt.o    = ctx_r.rem[0].offset;
              ctx_nxt.an   = ctx_r.rem[0].anon;
              ctx_nxt.mode = M_PUT;
              restart      = 1'b1;
            end
          end
          M_PUT: begin
            if (!ctx_r.free_v) begin
              ctx_nxt.res.status = ST_FULL;
              state_nxt          = S_OUT;
            end else begin
              state_nxt = S_LEN;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_LEN: begin
        alu_req = '{a: ctx_r.e, b: ctx_r.s, sub: 1'b1};
        if (ctx_r.erase && !ctx_r.rem_i && ctx_r.rem_n == 2'd2) begin
          ctx_nxt.pend_v   = 1'b1;
          ctx_nxt.pend_idx = ctx_r.free_idx;
          ctx_nxt.pend_ent = '{start: ctx_r.s, length: alu_rsp.res,
                               offset: ctx_r.o, anon: ctx_r.an};
          ctx_nxt.s        = ctx_r.rem[1].start;
          ctx_nxt.e        = ctx_r.rem[1].length;
          ctx_nxt.o        = ctx_r.rem[1].offset;
          ctx_nxt.an       = ctx_r.rem[1].anon;
          ctx_nxt.rem_i    = 1'b1;
          restart          = 1'b1;
        end else begin
          wr_en  = 1'b1;
          wr_idx = ctx_r.free_idx;
          wr_ent = '{start: ctx_r.s, length: alu_rsp.res, offset: ctx_r.o, anon: ctx_r.an};
          valid_nxt = valid_r & ~ctx_r.kill;
          valid_nxt[ctx_r.free_idx] = 1'b1;
          if (ctx_r.pend_v) begin
            valid_nxt[ctx_r.pend_idx] = 1'b1;
            state_nxt = S_WR2;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      S_WR2: begin
        wr_en     = 1'b1;
        wr_idx    = ctx_r.pend_idx;
        wr_ent    = ctx_r.pend_ent;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = ctx_r.res;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (adv) begin
      if (ctx_r.idx == LAST) begin
        state_nxt = S_END;
      end else begin
        ctx_nxt.idx = ctx_r.idx + 1'b1;
        state_nxt   = S_SCAN;
      end
    end
    if (restart) begin
      ctx_nxt.idx    = '0;
      ctx_nxt.free_v = 1'b0;
      state_nxt      = S_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
    ctx_r <= ctx_nxt;
  end
endmodule

[tb/testbench.sv]
// testbench: checks address_region_map_table_top against a built-in table predictor
// depends on armt_pkg, armt_in_if, armt_out_if and the top level rtl
`timescale 1ns / 100ps

module testbench;
  import armt_pkg::*;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 430;

  typedef struct {
    logic [1:0]  action;
    logic [63:0] address;
    logic [63:0] length;
    logic [63:0] file_offset;
    logic        anonymous;
  } region_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  armt_in_if  in_ch ();
  armt_out_if out_ch ();

  address_region_map_table_top #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted table and scratch copy
  bit          map_valid [ENTRIES];
  logic [63:0] map_start [ENTRIES];
  logic [63:0] map_len   [ENTRIES];
  logic [63:0] map_off   [ENTRIES];
  bit          map_anon  [ENTRIES];
  bit          scr_valid [ENTRIES];
  logic [63:0] scr_start [ENTRIES];
  logic [63:0] scr_len   [ENTRIES];
  logic [63:0] scr_off   [ENTRIES];
  bit          scr_anon  [ENTRIES];

  region_req_t req_queue[$];
  res_t        expected_results[$];
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          stim_done = 1'b0;
  logic [63:0] bases [4];

  function automatic bit mappings_agree(logic [63:0] sa, logic [63:0] oa, bit na,
                                        logic [63:0] sb, logic [63:0] ob, bit nb);
    if (na && nb) return 1'b1;
    if (na || nb) return 1'b0;
    return (sa - sb) == (oa - ob);
  endfunction

  function automatic logic [1:0] scr_insert(logic [63:0] s, logic [63:0] l,
                                            logic [63:0] o, bit an);
    logic [63:0] e, os, oe, oo;
    bit again, on, ok, drop;
    e = s + l;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!scr_valid[i]) continue;
        os = scr_start[i];
        oe = os + scr_len[i];
        oo = scr_off[i];
        on = scr_anon[i];
        if (oe < s || os > e) continue;
        ok = mappings_agree(s, o, an, os, oo, on);
        drop = 1'b1;
        if (s >= os && e <= oe) begin
          if (!ok) return ST_INCONS;
          s = os; e = oe; o = oo; an = on;
        end else if (os >= s && oe <= e) begin
          if (!ok) return ST_INCONS;
        end else if (e == os) begin
          if (!ok) drop = 1'b0;
          else e = oe;
        end else if (oe == s) begin
          if (!ok) drop = 1'b0;
          else begin
            s = os; o = oo; an = on;
          end
        end else if (s < os) begin
          if (!ok) return ST_INCONS;
          e = oe;
        end else begin
          if (!ok) return ST_INCONS;
          s = os; o = oo; an = on;
        end
        if (drop) begin
          scr_valid[i] = 1'b0;
          again = 1'b1;
          break;
        end
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!scr_valid[i]) begin
        scr_valid[i] = 1'b1;
        scr_start[i] = s;
        scr_len[i]   = e - s;
        scr_off[i]   = o;
        scr_anon[i]  = an;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic logic [1:0] scr_erase(logic [63:0] s, logic [63:0] l);
    logic [63:0] e, os, oe, oo;
    logic [63:0] ks [2];
    logic [63:0] kl [2];
    logic [63:0] ko [2];
    bit ka [2];
    bit on;
    int n;
    logic [1:0] st;
    e = s + l;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!scr_valid[i]) continue;
      os = scr_start[i];
      oe = os + scr_len[i];
      oo = scr_off[i];
      on = scr_anon[i];
      if (e <= os || oe <= s) continue;
      if (s > os && n < 2) begin
        ks[n] = os; kl[n] = s - os; ko[n] = oo; ka[n] = on; n++;
      end
      if (e < oe && n < 2) begin
        ks[n] = e; kl[n] = oe - e; ko[n] = on ? oo : oo + (e - os); ka[n] = on; n++;
      end
      scr_valid[i] = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      st = scr_insert(ks[i], kl[i], ko[i], ka[i]);
      if (st != ST_OK) return st;
    end
    return ST_OK;
  endfunction

  function automatic res_t map_apply(region_req_t r);
    res_t x;
    logic [63:0] ln;
    logic [1:0] st;
    x = '0;
    st = ST_OK;
    if (r.action == ACT_INSERT || r.action == ACT_ERASE) begin
      ln = (r.length > ~r.address) ? ~r.address : r.length;
      if (ln != 0) begin
        scr_valid = map_valid; scr_start = map_start; scr_len = map_len;
        scr_off = map_off; scr_anon = map_anon;
        st = (r.action == ACT_INSERT) ? scr_insert(r.address, ln, r.file_offset, r.anonymous)
                                      : scr_erase(r.address, ln);
        if (st == ST_OK) begin
          map_valid = scr_valid; map_start = scr_start; map_len = scr_len;
          map_off = scr_off; map_anon = scr_anon;
        end
      end
    end else if (r.action == ACT_LOOKUP) begin
      st = ST_NOT_MAPPED;
      for (int i = 0; i < ENTRIES; i++) begin
        if (map_valid[i] && r.address >= map_start[i] &&
            r.address - map_start[i] < map_len[i]) begin
          st = ST_OK;
          x.start  = map_start[i];
          x.length = map_len[i];
          x.offset = map_off[i];
          x.anon   = map_anon[i];
          x.trans  = map_off[i] + (r.address - map_start[i]);
          break;
        end
      end
    end
    x.status = st;
    return x;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_word(logic [1:0] a, logic [63:0] ad, logic [63:0] ln,
                           logic [63:0] of, logic an);
    region_req_t r;
    r.action = a; r.address = ad; r.length = ln; r.file_offset = of; r.anonymous = an;
    req_queue.insert(req_queue.size(), r);
  endtask

  task automatic push_random_word();
    int unsigned kind;
    logic [63:0] ad, ln, of;
    logic an;
    kind = $urandom_range(0, 99);
    ad = bases[$urandom_range(0, 3)] + 64'($urandom_range(0, 4095) & 32'hfff0);
    ln = ($urandom_range(0, 15) == 0) ? 64'd0 : 64'($urandom_range(1, 512));
    case ($urandom_range(0, 3))
      0, 1: of = ad;
      2: of = ad + 64'h10000;
      default: of = rand64();
    endcase
    an = ($urandom_range(0, 4) == 0);
    if (kind < 40) push_word(ACT_INSERT, ad, ln, of, an);
    else if (kind < 58) push_word(ACT_ERASE, ad, ln, of, an);
    else if (kind < 85) push_word(ACT_LOOKUP, ad + 64'($urandom_range(0, 64)), ln, of, an);
    else if (kind < 94)
      push_word(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), 1'($urandom));
    else push_word(ACT_ERASE, ad & ~64'hffff, 64'h1_0000, of, an);
  endtask

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    bases[0] = 64'h0;
    bases[1] = 64'h8000_0000_0000_0000;
    bases[2] = 64'hffff_ffff_ffff_f000;
    bases[3] = rand64() & ~64'hffff;

    // directed words
    push_word(ACT_INSERT, 64'h1000, 64'h100, 64'h5000, 1'b0);
    push_word(ACT_LOOKUP, 64'h1080, 64'h0, 64'h0, 1'b0);
    push_word(ACT_LOOKUP, 64'h1100, 64'h0, 64'h0, 1'b0);
    push_word(ACT_INSERT, 64'h1100, 64'h80, 64'h5100, 1'b0);
    push_word(ACT_INSERT, 64'h1180, 64'h40, 64'h9999, 1'b0);
    push_word(ACT_INSERT, 64'h1050, 64'h40, 64'h7777, 1'b0);
    push_word(ACT_INSERT, 64'h0f00, 64'h180, 64'h4f00, 1'b0);
    push_word(ACT_INSERT, 64'h1000, 64'h10, 64'h5000, 1'b0);
    push_word(ACT_LOOKUP, 64'h0f10, 64'h0, 64'h0, 1'b0);
    push_word(ACT_INSERT, 64'h3000, 64'h100, 64'h0, 1'b1);
    push_word(ACT_INSERT, 64'h3080, 64'h100, 64'hdead, 1'b1);
    push_word(ACT_INSERT, 64'h3180, 64'h10, 64'h3180, 1'b0);
    push_word(ACT_ERASE, 64'h1040, 64'h20, 64'h0, 1'b0);
    push_word(ACT_LOOKUP, 64'h1070, 64'h0, 64'h0, 1'b0);
    push_word(ACT_ERASE, 64'h3000, 64'h40, 64'h0, 1'b0);
    push_word(ACT_INSERT, 64'h9000, 64'h0, 64'h0, 1'b0);
    push_word(ACT_ERASE, 64'h1000, 64'h0, 64'h0, 1'b0);
    push_word(ACT_INSERT, 64'hffff_ffff_ffff_ff00, '1, '1, 1'b0);
    push_word(ACT_LOOKUP, '1, '1, '1, 1'b1);
    push_word(ACT_LOOKUP, 64'hffff_ffff_ffff_fffe, 64'h0, 64'h0, 1'b0);
    push_word(2'd3, '1, '1, '1, 1'b1);
    for (int i = 0; i < 17; i++) push_word(ACT_INSERT, 64'h20000 + i * 64'h100, 64'h10,
                                           64'(i) << 40, 1'b0);
    push_word(ACT_ERASE, 64'h20004, 64'h4, 64'h0, 1'b0);
    push_word(ACT_ERASE, 64'h0, '1, 64'h0, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) push_random_word();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (req_queue.size() != 0 || in_ch.valid !== 1'b0 || expected_results.size() != 0);
    stim_done = 1'b1;
    repeat (3000) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    int unsigned gap_pct;
    bit take;
    region_req_t r;
    if (rst_n) begin
      take = 1'b1;
      if (in_ch.valid && in_ch.ready) begin
        r.action = in_ch.action; r.address = in_ch.address; r.length = in_ch.length;
        r.file_offset = in_ch.file_offset; r.anonymous = in_ch.anonymous;
        expected_results.insert(expected_results.size(), map_apply(r));
        words_sent++;
      end else if (in_ch.valid) begin
        take = 1'b0;
      end
      if (take) begin
        gap_pct = (words_sent < 150) ? 26 : (words_sent < 300) ? 63 : 0;
        if (req_queue.size() == 0 || $urandom_range(0, 99) < gap_pct ||
            (words_sent == 200 && expected_results.size() != 0)) begin
          in_ch.valid <= 1'b0;
        end else begin
          r = req_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= r.action;
          in_ch.address <= r.address;
          in_ch.length <= r.length;
          in_ch.file_offset <= r.file_offset;
          in_ch.anonymous <= r.anonymous;
        end
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    int unsigned stall_pct;
    res_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word, status %0d", out_ch.status);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status || out_ch.region_start !== want.start ||
              out_ch.region_length !== want.length || out_ch.region_offset !== want.offset ||
              out_ch.region_is_anonymous !== want.anon ||
              out_ch.translated_offset !== want.trans) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch word %0d: exp st=%0d s=%h l=%h o=%h a=%b t=%h",
                       results_seen, want.status, want.start, want.length, want.offset,
                       want.anon, want.trans);
              $display("  got st=%0d s=%h l=%h o=%h a=%b t=%h",
                       out_ch.status, out_ch.region_start, out_ch.region_length,
                       out_ch.region_offset, out_ch.region_is_anonymous,
                       out_ch.translated_offset);
            end
          end
        end
      end
      if (!hold_done && results_seen == 120) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      stall_pct = (words_sent < 150) ? 63 : (words_sent < 300) ? 26 : 0;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || stim_done)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
